// ===== rtl/delimiter_string_tokenizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the delimiter string tokenizer
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DELIMITER_STRING_TOKENIZER_ASSERT_SVH
`define DELIMITER_STRING_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define DST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication.
`define DST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== rtl/dst_pkg.sv =====
// ----------------------------------------------------------------------------
// dst_pkg
// Types, constants and helpers shared by the delimiter string tokenizer.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int unsigned MAX_DELIM_BYTES = 4;
    localparam int unsigned POSITION_BITS   = 16;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned COUNT_W = 3;

    // Position limit: 2^POSITION_BITS - 1, capped at the 16-bit field range.
    localparam logic [POS_W-1:0] POS_LIMIT = (POSITION_BITS >= POS_W) ?
        {POS_W{1'b1}} : POS_W'((64'd1 << POSITION_BITS) - 64'd1);

    // Largest usable delimiter count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = (MAX_DELIM_BYTES < 4) ?
        COUNT_W'(MAX_DELIM_BYTES) : COUNT_W'(4);

    localparam logic [7:0] SPACE_LIMIT = 8'd32;

    // Configuration register indexes
    localparam logic [1:0] REG_SPLIT_MODE      = 2'd0;
    localparam logic [1:0] REG_DELIMITER_COUNT = 2'd1;
    localparam logic [1:0] REG_DELIMITER_BYTES = 2'd2;

    localparam logic [1:0]  RESET_SPLIT_MODE      = 2'd0;
    localparam logic [2:0]  RESET_DELIMITER_COUNT = 3'd1;
    localparam logic [31:0] RESET_DELIMITER_BYTES = 32'd44;

    typedef enum logic [1:0] {
        MODE_SPACE = 2'd0,
        MODE_ANY   = 2'd1,
        MODE_SEQ   = 2'd2,
        MODE_RSVD  = 2'd3
    } dst_mode_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  count;
        logic [31:0] delims;
    } dst_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] byte_pos;
        logic [POS_W-1:0] tok_start;
        logic [23:0]      recent;
        logic             in_tok;
        logic             ovf;
    } dst_state_t;

    typedef struct packed {
        logic             ovf;
        logic             valid;
        logic             last;
        logic [POS_W-1:0] length;
        logic [POS_W-1:0] start;
    } dst_result_t;

    function automatic logic [COUNT_W-1:0] eff_count(input logic [2:0] raw);
        logic [COUNT_W-1:0] c;
        c = raw;
        if (c == '0)
        begin
            c = COUNT_W'(1);
        end
        if (c > COUNT_MAX)
        begin
            c = COUNT_MAX;
        end
        return c;
    endfunction

endpackage

// ===== rtl/dst_step.sv =====
// ----------------------------------------------------------------------------
// dst_step
// Next-state and result logic for one accepted string item.
// ----------------------------------------------------------------------------
module dst_step
    import dst_pkg::*;
(
    input  dst_cfg_t    cfg,
    input  dst_state_t  cur,
    input  logic [7:0]  char_byte,
    input  logic        has_byte,
    input  logic        end_of_string,
    output dst_state_t  nxt,
    output dst_result_t res0,
    output dst_result_t res1,
    output logic [1:0]  res_count
);

    dst_mode_t          mode;
    logic [COUNT_W-1:0] cnt;
    logic               at_limit;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_plus1;
    logic [POS_W-1:0]   clamp_start;
    logic               any_hit;
    logic               seq_range;
    logic               seq_match;
    logic [31:0]        window;
    logic [1:0]         want_idx [4];
    logic [POS_W-1:0]   match_start;
    logic               byte_hit;
    dst_result_t        byte_res;
    dst_state_t         upd;
    logic [POS_W-1:0]   end_len;
    logic [POS_W-1:0]   end_st;
    logic               end_tok;
    dst_result_t        end_res;
    dst_result_t        bare_res;

    assign mode        = (cfg.mode == MODE_RSVD) ? MODE_SPACE : dst_mode_t'(cfg.mode);
    assign cnt         = eff_count(cfg.count);
    assign at_limit    = cur.byte_pos >= POS_LIMIT;
    assign pos         = at_limit ? (POS_LIMIT - POS_W'(1)) : cur.byte_pos;
    assign pos_plus1   = pos + POS_W'(1);
    assign clamp_start = (cur.tok_start < pos) ? cur.tok_start : pos;
    assign window      = {cur.recent, char_byte};
    assign match_start = pos_plus1 - POS_W'(cnt);

    // Delimiter compares: set membership and sequence match, newest byte first.
    always_comb
    begin
        any_hit   = 1'b0;
        seq_match = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            want_idx[k] = 2'(cnt - 3'd1 - 3'(k));
            if (3'(k) < cnt)
            begin
                if (cfg.delims[8*k +: 8] == char_byte)
                begin
                    any_hit = 1'b1;
                end
                if (window[8*k +: 8] != cfg.delims[8*want_idx[k] +: 8])
                begin
                    seq_match = 1'b0;
                end
            end
        end
    end

    assign seq_range = ({1'b0, pos} + 17'd1) >= ({1'b0, cur.tok_start} + 17'(cnt));

    // Byte step
    always_comb
    begin
        upd      = cur;
        byte_hit = 1'b0;
        byte_res = '0;
        if (has_byte)
        begin
            unique case (mode)
                MODE_ANY:
                begin
                    if (any_hit)
                    begin
                        byte_hit        = 1'b1;
                        byte_res.start  = clamp_start;
                        byte_res.length = pos - clamp_start;
                        upd.tok_start   = pos_plus1;
                    end
                end
                MODE_SEQ:
                begin
                    if (seq_range && seq_match)
                    begin
                        byte_hit        = 1'b1;
                        byte_res.start  = cur.tok_start;
                        byte_res.length = match_start - cur.tok_start;
                        upd.tok_start   = pos_plus1;
                    end
                end
                default:
                begin
                    if (char_byte <= SPACE_LIMIT)
                    begin
                        if (cur.in_tok)
                        begin
                            byte_hit        = 1'b1;
                            byte_res.start  = clamp_start;
                            byte_res.length = pos - clamp_start;
                            upd.in_tok      = 1'b0;
                        end
                    end
                    else if (!cur.in_tok)
                    begin
                        upd.in_tok    = 1'b1;
                        upd.tok_start = pos;
                    end
                end
            endcase
            upd.recent = window[23:0];
            if (at_limit)
            begin
                upd.ovf = 1'b1;
            end
            else
            begin
                upd.byte_pos = cur.byte_pos + POS_W'(1);
            end
        end
        byte_res.valid = 1'b1;
        byte_res.ovf   = upd.ovf;
    end

    // Closing token at end of string
    assign end_len = upd.byte_pos;
    assign end_st  = upd.tok_start;

    always_comb
    begin
        end_tok = 1'b0;
        end_res = '0;
        if (mode == MODE_SPACE)
        begin
            end_tok        = upd.in_tok;
            end_res.start  = (end_st > end_len) ? end_len : end_st;
            end_res.length = end_len - end_res.start;
        end
        else if (end_st < end_len)
        begin
            end_tok        = 1'b1;
            end_res.start  = end_st;
            end_res.length = end_len - end_st;
        end
        else if (end_len != '0)
        begin
            // String ended right after a delimiter: trailing empty token.
            end_tok        = 1'b1;
            end_res.start  = end_len - POS_W'(1);
            end_res.length = '0;
        end
        end_res.valid = 1'b1;
        end_res.last  = 1'b1;
        end_res.ovf   = upd.ovf;
    end

    always_comb
    begin
        bare_res      = '0;
        bare_res.last = 1'b1;
        bare_res.ovf  = upd.ovf;
    end

    // Order results: byte token first, closing token or end marker last.
    always_comb
    begin
        res1 = end_res;
        if (byte_hit)
        begin
            res0      = byte_res;
            res0.last = end_of_string && !end_tok;
        end
        else if (end_tok)
        begin
            res0 = end_res;
        end
        else
        begin
            res0 = bare_res;
        end
        if (byte_hit && end_of_string && end_tok)
        begin
            res_count = 2'd2;
        end
        else if (byte_hit || end_of_string)
        begin
            res_count = 2'd1;
        end
        else
        begin
            res_count = 2'd0;
        end
        nxt = end_of_string ? dst_state_t'('0) : upd;
    end

endmodule

// ===== rtl/delimiter_string_tokenizer.sv =====
// ----------------------------------------------------------------------------
// delimiter_string_tokenizer
// Splits a byte stream into tokens and reports start position and length.
// ----------------------------------------------------------------------------
// Input channel (s_*): one string byte per transfer; s_tuser marks whether
// s_tdata carries a byte, s_tlast ends the string. Output channel (m_*):
// one token per transfer, start in m_tdata[15:0], length in m_tdata[31:16],
// m_tlast on the final result of a string.
// A transfer is worked out in the cycle it is taken and its results are
// written to a four-entry result queue, from which they are offered on m_*
// in order. Input rate is one transfer per cycle while s_tready is high.
// A transfer yields zero, one or two results, and the output side drains one
// per cycle while m_tready is high; in the delimiter modes a string whose
// final byte is a delimiter yields two (the closed token and a trailing empty
// one). s_tready falls when fewer than two queue entries are free, which can
// also happen while the receiver holds m_tready low.
// Reset empties the queue, clears the string state and loads the register
// defaults: whitespace mode, one delimiter, delimiter byte ','.
// Configuration writes take effect with the next input transfer.
// ----------------------------------------------------------------------------
module delimiter_string_tokenizer
    import dst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [1:0]  m_tuser,   // [0] token_valid, [1] overflow
    output logic        m_tlast    // last_result
);

    dst_cfg_t    cfg_reg;
    dst_state_t  state_reg;
    dst_state_t  state_next;
    dst_result_t res0;
    dst_result_t res1;
    logic [1:0]  res_count;
    dst_result_t queue_mem [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [1:0]  push_count;
    logic        accept;
    logic        pop;

    assign s_tready   = count_reg <= 3'd2;
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = count_reg != 3'd0;
    assign pop        = m_tvalid && m_tready;
    assign push_count = accept ? res_count : 2'd0;
    assign count_next = count_reg + 3'(push_count) - 3'(pop);

    assign m_tdata = {queue_mem[rd_ptr_reg].length, queue_mem[rd_ptr_reg].start};
    assign m_tuser = {queue_mem[rd_ptr_reg].ovf, queue_mem[rd_ptr_reg].valid};
    assign m_tlast = queue_mem[rd_ptr_reg].last;

    dst_step u_step (
        .cfg           (cfg_reg),
        .cur           (state_reg),
        .char_byte     (s_tdata),
        .has_byte      (s_tuser[0]),
        .end_of_string (s_tlast),
        .nxt           (state_next),
        .res0          (res0),
        .res1          (res1),
        .res_count     (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= RESET_SPLIT_MODE;
            cfg_reg.count  <= RESET_DELIMITER_COUNT;
            cfg_reg.delims <= RESET_DELIMITER_BYTES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPLIT_MODE:      cfg_reg.mode   <= cfg_data[1:0];
                REG_DELIMITER_COUNT: cfg_reg.count  <= cfg_data[2:0];
                REG_DELIMITER_BYTES: cfg_reg.delims <= cfg_data;
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push_count;
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            count_reg  <= count_next;
        end
    end

    // Result queue payload
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (push_count == 2'd2)
        begin
            queue_mem[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule

// ===== rtl/dst_checker.sv =====
// ----------------------------------------------------------------------------
// dst_checker
// Port-level checks for the delimiter string tokenizer, bound to the top.
// ----------------------------------------------------------------------------
`include "delimiter_string_tokenizer_assert.svh"

module dst_checker
    import dst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic [16:0] token_end;

    assign token_end = {1'b0, m_tdata[15:0]} + {1'b0, m_tdata[31:16]};

    // Hold a stalled result.
    `DST_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Input backpressure only while results are waiting.
    `DST_ASSERT_NOW(a_stall_has_backlog, clk, rst_n, !s_tready, m_tvalid)

    // A bare end marker is the last result of its string and carries zeros.
    `DST_ASSERT_NOW(a_bare_marker, clk, rst_n, m_tvalid && !m_tuser[0],
        m_tlast && (m_tdata == 32'd0))

    // A token never reaches past the position range.
    `DST_ASSERT_NOW(a_token_in_range, clk, rst_n, m_tvalid && m_tuser[0],
        token_end <= 17'(POS_LIMIT))

endmodule

bind delimiter_string_tokenizer dst_checker u_dst_checker (.*);

// ===== tb/tb_delimiter_string_tokenizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delimiter_string_tokenizer
// Self-checking testbench: drives strings byte by byte into the tokenizer under
// all split modes and varied delimiter settings, predicts each token report or
// takes it from the directed table, and compares each output transfer field by
// field. Directed rows first, then random strings; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_delimiter_string_tokenizer;
    import dst_pkg::*;

    localparam int MAX_GAP        = 8;
    localparam int DRAIN_SETTLE   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 40;

    // How the expectation of a directed row is formed
    localparam int PREDICTED  = -1;
    localparam int NO_RESULT  = 0;
    localparam int ONE_RESULT = 1;

    localparam dst_result_t END_MARK =
        '{ovf: 1'b0, valid: 1'b0, last: 1'b1, length: 16'd0, start: 16'd0};
    localparam dst_result_t FIRST_TOKEN =
        '{ovf: 1'b0, valid: 1'b1, last: 1'b0, length: 16'd1, start: 16'd0};

    typedef struct {
        bit          reconfigure;
        dst_mode_t   mode;
        logic [2:0]  count;
        logic [31:0] delims;
        logic [7:0]  ch;
        logic        has;
        logic        eos;
        int          typed_n;
        dst_result_t typed;
    } stim_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] char_byte
    logic [0:0]  s_tuser   = '0;   // [0] has_byte
    logic        s_tlast   = 1'b0; // end_of_string
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [15:0] token_start, [31:16] token_length
    logic [1:0]  m_tuser;          // [0] token_valid, [1] overflow
    logic        m_tlast;          // last_result

    // Predictor copy of the registers and the string state
    dst_mode_t   split_sel;
    logic [2:0]  delim_count_reg;
    logic [31:0] delim_set;
    logic [15:0] byte_count;
    logic [15:0] token_begin;
    logic [23:0] byte_history;
    logic        in_token;
    logic        pos_saturated;

    dst_result_t pending_tokens[$];
    stim_row_t   directed_rows[$];
    bit          no_gaps     = 1'b0;
    int          mismatches  = 0;
    int          tokens_seen = 0;
    int          items_sent  = 0;
    int          strings_sent = 0;
    int          idle_cycles = 0;

    delimiter_string_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int active_count();
        int cnt;
        cnt = (delim_count_reg == 3'd0) ? 1 : int'(delim_count_reg);
        if (cnt > int'(MAX_DELIM_BYTES))
        begin
            cnt = MAX_DELIM_BYTES;
        end
        if (cnt > 4)
        begin
            cnt = 4;
        end
        return cnt;
    endfunction

    function automatic dst_result_t token_of(input int unsigned start, input int unsigned len,
                                             input logic valid);
        dst_result_t tok;
        tok        = '0;
        tok.start  = 16'(start);
        tok.length = 16'(len);
        tok.valid  = valid;
        return tok;
    endfunction

    function automatic void clear_string_state();
        byte_count    = '0;
        token_begin   = '0;
        byte_history  = '0;
        in_token      = 1'b0;
        pos_saturated = 1'b0;
    endfunction

    // Advance the string state by one item and collect the tokens it closes.
    function automatic void tokenize_byte(input logic [7:0] b, input logic has, input logic eos,
                                          output dst_result_t found[$]);
        dst_mode_t   mode;
        int          cnt;
        int          k;
        int unsigned p;
        int unsigned s;
        int unsigned ms;
        int unsigned len;
        int unsigned st;
        logic [7:0]  got;
        bit          ov;
        bit          hit;
        found.delete();
        mode = (split_sel == MODE_RSVD) ? MODE_SPACE : split_sel;
        cnt  = active_count();
        if (has)
        begin
            ov = byte_count >= POS_LIMIT;
            p  = ov ? int'(POS_LIMIT) - 1 : byte_count;
            s  = (token_begin < p) ? token_begin : p;
            case (mode)
                MODE_SPACE:
                begin
                    if (b <= SPACE_LIMIT)
                    begin
                        if (in_token)
                        begin
                            found    = {found, token_of(s, p - s, 1'b1)};
                            in_token = 1'b0;
                        end
                    end
                    else if (!in_token)
                    begin
                        in_token    = 1'b1;
                        token_begin = 16'(p);
                    end
                end
                MODE_ANY:
                begin
                    hit = 1'b0;
                    for (k = 0; k < cnt; k++)
                    begin
                        if (delim_set[8 * k +: 8] == b)
                        begin
                            hit = 1'b1;
                        end
                    end
                    if (hit)
                    begin
                        found       = {found, token_of(s, p - s, 1'b1)};
                        token_begin = 16'(p + 1);
                    end
                end
                default:
                begin
                    // newest byte against the last delimiter byte, history against earlier ones
                    hit = (p + 1 >= token_begin + cnt);
                    for (k = 0; k < cnt; k++)
                    begin
                        got = (k == 0) ? b : 8'(byte_history >> (8 * (k - 1)));
                        if (got != delim_set[8 * (cnt - 1 - k) +: 8])
                        begin
                            hit = 1'b0;
                        end
                    end
                    if (hit)
                    begin
                        ms          = p + 1 - cnt;
                        found       = {found, token_of(token_begin, ms - token_begin, 1'b1)};
                        token_begin = 16'(p + 1);
                    end
                end
            endcase
            byte_history = {byte_history[15:0], b};
            if (ov)
            begin
                pos_saturated = 1'b1;
            end
            else
            begin
                byte_count = byte_count + 16'd1;
            end
        end
        if (eos)
        begin
            len = byte_count;
            st  = token_begin;
            if (mode == MODE_SPACE)
            begin
                if (in_token)
                begin
                    if (st > len)
                    begin
                        st = len;
                    end
                    found = {found, token_of(st, len - st, 1'b1)};
                end
            end
            else if (st < len)
            begin
                found = {found, token_of(st, len - st, 1'b1)};
            end
            else if (len > 0)
            begin
                // string ended right after a delimiter: trailing empty token
                found = {found, token_of(len - 1, 0, 1'b1)};
            end
            if (found.size() == 0)
            begin
                found = {found, token_of(0, 0, 1'b0)};
            end
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i])
        begin
            found[i].ovf = pos_saturated;
        end
        if (eos)
        begin
            clear_string_state();
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: token %0d %s mismatch, expected %0d, actual %0d",
                     $time, tokens_seen, name, want, got);
        end
    endfunction

    // Output monitor: every transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        dst_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected token, expected none, actual start %0d length %0d",
                         $time, m_tdata[15:0], m_tdata[31:16]);
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_start", want.start, m_tdata[15:0]);
                check_field("token_length", want.length, m_tdata[31:16]);
                check_field("token_valid", 16'(want.valid), 16'(m_tuser[0]));
                check_field("overflow", 16'(want.ovf), 16'(m_tuser[1]));
                check_field("last_result", 16'(want.last), 16'(m_tlast));
            end
            tokens_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d tokens still expected",
                     $time, idle_cycles, pending_tokens.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stall before each token, none while no_gaps is set.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [7:0] ch, input logic has, input logic eos,
                             input int typed_n, input dst_result_t typed);
        int          gap;
        dst_result_t found[$];
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= has;
        s_tlast  <= eos;
        do @(posedge clk); while (!s_tready);
        tokenize_byte(ch, has, eos, found);
        if (typed_n != PREDICTED)
        begin
            found.delete();
            if (typed_n == ONE_RESULT)
            begin
                found = {found, typed};
            end
        end
        foreach (found[i])
        begin
            pending_tokens = {pending_tokens, found[i]};
        end
        if (has || eos)
        begin
            items_sent++;
        end
        if (eos)
        begin
            strings_sent++;
        end
    endtask

    // Hold the input side until every expected token is out and the block is idle.
    task automatic wait_for_tokens();
        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_settings(input dst_mode_t mode, input logic [2:0] count,
                                  input logic [31:0] delims);
        wait_for_tokens();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPLIT_MODE;
        cfg_data  <= 32'(mode);
        @(posedge clk);
        cfg_index <= REG_DELIMITER_COUNT;
        cfg_data  <= 32'(count);
        @(posedge clk);
        cfg_index <= REG_DELIMITER_BYTES;
        cfg_data  <= delims;
        @(posedge clk);
        cfg_we    <= 1'b0;
        split_sel       = mode;
        delim_count_reg = count;
        delim_set       = delims;
    endtask

    // Random string: delimiter bytes, whitespace, arbitrary bytes, byte-less items
    // and, in sequence mode, whole or cut-off delimiter sequences.
    task automatic send_string(input int len);
        int         sent;
        int         seq_left;
        int         seq_idx;
        int         pick;
        bit         close_on_byte;
        logic [7:0] ch;
        sent          = 0;
        seq_left      = 0;
        seq_idx       = 0;
        close_on_byte = (len > 0) && ($urandom_range(0, 3) != 0);
        while (sent < len)
        begin
            if ($urandom_range(0, 59) == 0)
            begin
                wait_for_tokens();
            end
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b0, PREDICTED, '0);
            end
            if (seq_left == 0 && split_sel == MODE_SEQ && $urandom_range(0, 2) == 0)
            begin
                seq_left = $urandom_range(1, active_count());
                seq_idx  = 0;
            end
            if (seq_left > 0)
            begin
                ch = delim_set[8 * seq_idx +: 8];
                seq_idx++;
                seq_left--;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 3)
                begin
                    ch = delim_set[8 * $urandom_range(0, 3) +: 8];
                end
                else if (pick <= 5)
                begin
                    ch = 8'($urandom_range(0, 32));
                end
                else if (pick == 6)
                begin
                    ch = 8'($urandom_range(32, 33));
                end
                else
                begin
                    ch = 8'($urandom);
                end
            end
            send_item(ch, 1'b1, close_on_byte && (sent == len - 1), PREDICTED, '0);
            sent++;
        end
        if (!close_on_byte)
        begin
            send_item(8'($urandom), 1'b0, 1'b1, PREDICTED, '0);
        end
    endtask

    task automatic add_settings(input dst_mode_t mode, input logic [2:0] count,
                                input logic [31:0] delims);
        stim_row_t r;
        r.reconfigure = 1'b1;
        r.mode        = mode;
        r.count       = count;
        r.delims      = delims;
        r.ch          = '0;
        r.has         = 1'b0;
        r.eos         = 1'b0;
        r.typed_n     = NO_RESULT;
        r.typed       = '0;
        directed_rows = {directed_rows, r};
    endtask

    task automatic add_item(input logic [7:0] ch, input logic has, input logic eos,
                            input int typed_n, input dst_result_t typed);
        stim_row_t r;
        r.reconfigure = 1'b0;
        r.mode        = MODE_SPACE;
        r.count       = '0;
        r.delims      = '0;
        r.ch          = ch;
        r.has         = has;
        r.eos         = eos;
        r.typed_n     = typed_n;
        r.typed       = typed;
        directed_rows = {directed_rows, r};
    endtask

    initial
    begin
        int          phase;
        int          first_item;
        dst_mode_t   mode;
        logic [2:0]  count;
        logic [31:0] delims;
        split_sel       = dst_mode_t'(RESET_SPLIT_MODE);
        delim_count_reg = RESET_DELIMITER_COUNT;
        delim_set       = RESET_DELIMITER_BYTES;
        clear_string_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Whitespace mode from reset defaults
        add_item(8'h00, 1'b0, 1'b1, ONE_RESULT, END_MARK);      // empty string
        add_item(8'hFF, 1'b0, 1'b0, NO_RESULT, '0);             // no byte, no end
        add_item(8'h20, 1'b1, 1'b1, ONE_RESULT, END_MARK);      // whitespace only
        add_item(8'h41, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h00, 1'b1, 1'b0, ONE_RESULT, FIRST_TOKEN);
        add_item(8'h80, 1'b1, 1'b0, PREDICTED, '0);             // high bytes are token bytes
        add_item(8'hFF, 1'b1, 1'b1, PREDICTED, '0);
        // Unused mode acts as whitespace, zero count acts as one
        add_settings(MODE_RSVD, 3'd0, 32'hFFFF_FFFF);
        add_item(8'h21, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h20, 1'b1, 1'b1, PREDICTED, '0);
        // Any-of mode, count above the maximum, empty tokens and a trailing one
        add_settings(MODE_ANY, 3'd7, 32'h2C3B_7C00);
        add_item(8'h2C, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h3B, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h78, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h00, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h2C, 1'b1, 1'b1, PREDICTED, '0);
        add_item(8'h00, 1'b0, 1'b1, ONE_RESULT, END_MARK);
        // Sequence mode with CR LF, back to back and at the very end
        add_settings(MODE_SEQ, 3'd2, 32'h0000_0A0D);
        add_item(8'h61, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h0D, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h0A, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h0D, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h0A, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h0D, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h0A, 1'b1, 1'b1, PREDICTED, '0);
        // Overlapping candidate matches: earliest wins, no overlap
        add_settings(MODE_SEQ, 3'd2, 32'h0000_6161);
        add_item(8'h61, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h61, 1'b1, 1'b0, PREDICTED, '0);
        add_item(8'h61, 1'b1, 1'b1, PREDICTED, '0);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].reconfigure)
            begin
                write_settings(directed_rows[r].mode, directed_rows[r].count,
                               directed_rows[r].delims);
            end
            else
            begin
                send_item(directed_rows[r].ch, directed_rows[r].has, directed_rows[r].eos,
                          directed_rows[r].typed_n, directed_rows[r].typed);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mode   = (phase < 8) ? dst_mode_t'(phase % 4) : ((phase == 8) ? MODE_SEQ : MODE_ANY);
            count  = (phase == 0) ? 3'd0 : (phase == 1) ? 3'd7 : (phase == 2) ? 3'd4 :
                     3'($urandom_range(0, 7));
            delims = (phase == 1) ? 32'h0000_0000 : (phase == 2) ? 32'hFFFF_FFFF : $urandom;
            write_settings(mode, count, delims);
            no_gaps    = ($urandom_range(0, 3) == 0);
            first_item = items_sent;
            while (items_sent - first_item < PHASE_ITEMS)
            begin
                send_string($urandom_range(0, 12));
            end
        end

        wait_for_tokens();
        repeat (8) @(posedge clk);
        $display("Covered %0d items in %0d strings over all split modes and delimiter counts,",
                 items_sent, strings_sent);
        $display("with random idling on both sides; %0d tokens checked.", tokens_seen);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== delimiter_string_tokenizer.f =====
+incdir+rtl
rtl/dst_pkg.sv
rtl/dst_step.sv
rtl/delimiter_string_tokenizer.sv
rtl/dst_checker.sv
tb/tb_delimiter_string_tokenizer.sv
